FILE: hdl/hbf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hbf_pkg;

  // Filter geometry
  localparam int TAP_COUNT = 39;
  localparam int TAP_W     = 6;
  localparam int CENTRE    = 19;

  // Sample, product and accumulator widths
  localparam int SMP_W  = 16;
  localparam int PROD_W = 32;
  localparam int ACC_W  = 40;
  localparam int OUT_SHIFT = 15;
  localparam int ENTRY_W = 4 * SMP_W;

  // Tag that follows one tap through the read and multiply stages
  typedef struct packed {
    logic             vld;
    logic             last;
    logic [TAP_W-1:0] tap;
  } hbf_tag_t;

  // Half-band coefficient for a tap; up path is doubled, centre clamped
  function automatic logic signed [SMP_W-1:0] tap_coef(input logic [TAP_W-1:0] tap,
                                                       input logic up);
    logic [TAP_W-1:0]        offs;
    logic signed [SMP_W-1:0] base;
    offs = (tap < TAP_W'(CENTRE)) ? (TAP_W'(CENTRE) - tap) : (tap - TAP_W'(CENTRE));
    case (offs)
      6'd1:    base = 16'sd10246;
      6'd3:    base = -16'sd2960;
      6'd5:    base = 16'sd1332;
      6'd7:    base = -16'sd616;
      6'd9:    base = 16'sd266;
      6'd11:   base = -16'sd103;
      6'd13:   base = 16'sd35;
      6'd15:   base = -16'sd10;
      6'd17:   base = 16'sd2;
      6'd19:   base = -16'sd1;
      default: base = 16'sd0;
    endcase
    if (offs == '0) begin
      tap_coef = up ? 16'sd32767 : 16'sd16384;
    end else begin
      tap_coef = up ? (base <<< 1) : base;
    end
  endfunction

endpackage

`default_nettype wire

FILE: hdl/halfband_fir_resampler_stereo.sv
// Stereo half-band FIR pair (39 taps) for down- and up-rate conversion.
// Input channel: in_valid/in_ready carries one down-rate and one up-rate
// stereo pair per transfer. The four samples are written to a circular
// history of HISTORY_DEPTH entries, then four lanes (down L/R, up L/R)
// each multiply-accumulate one tap per cycle over the 39 newest entries.
// Output channel: out_valid/out_ready carries the four filtered samples.
// Each result follows the 39 tap reads from the single history read
// port, then the product register, the last accumulate and the output
// register. The history is read once per tap, and the next transfer is
// taken only in the idle state, so the block does not take a new input
// before it is through with the last one. A new input is taken once
// the sums are loaded into the output register, while that result may
// still wait there; if the register is still full when the next sums
// are ready, the block holds them until the receiver takes the waiting
// result.
// Reset (rst_n low, synchronous) empties the history, so unwritten
// entries read as zero, clears the write position and drops any result.
`timescale 1ns / 1ps
`default_nettype none

module halfband_fir_resampler_stereo #(
  parameter int HISTORY_DEPTH = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [hbf_pkg::SMP_W-1:0]    in_down_in_left,
  input  wire logic signed [hbf_pkg::SMP_W-1:0]    in_down_in_right,
  input  wire logic signed [hbf_pkg::SMP_W-1:0]    in_up_in_left,
  input  wire logic signed [hbf_pkg::SMP_W-1:0]    in_up_in_right,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed      [hbf_pkg::SMP_W-1:0]    out_down_left,
  output logic signed      [hbf_pkg::SMP_W-1:0]    out_down_right,
  output logic signed      [hbf_pkg::SMP_W-1:0]    out_up_left,
  output logic signed      [hbf_pkg::SMP_W-1:0]    out_up_right
);

  localparam int AW = $clog2(HISTORY_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_RUN   = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  state_t                              state_r, state_nxt;
  logic [AW-1:0]                       rd_addr_r, rd_addr_nxt;
  logic [hbf_pkg::TAP_W-1:0]           tap_r, tap_nxt;
  logic                                in_xfer;
  logic                                load;
  logic                                lanes_done;
  logic [AW-1:0]                       base;
  hbf_pkg::hbf_tag_t                   issue_tag;
  hbf_pkg::hbf_tag_t                   rd_tag_q;
  logic [hbf_pkg::ENTRY_W-1:0]         wr_data;
  logic [hbf_pkg::ENTRY_W-1:0]         rd_data;
  logic signed [hbf_pkg::SMP_W-1:0]    coef_dn, coef_up;
  logic signed [hbf_pkg::ACC_W-1:0]    acc_dl, acc_dr, acc_ul, acc_ur;
  logic [3:0]                          done_v;

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;

  // History entry packing: down L, down R, up L, up R from the low end
  assign wr_data = {in_up_in_right, in_up_in_left, in_down_in_right, in_down_in_left};

  // Tap issue tag
  always_comb begin
    issue_tag      = '0;
    issue_tag.vld  = (state_r == S_RUN);
    issue_tag.last = (tap_r == hbf_pkg::TAP_W'(hbf_pkg::TAP_COUNT - 1));
    issue_tag.tap  = tap_r;
  end

  assign lanes_done = &done_v;
  assign load       = (state_r == S_DRAIN) && lanes_done && (!out_valid || out_ready);

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    rd_addr_nxt = rd_addr_r;
    tap_nxt     = tap_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          rd_addr_nxt = base;
          tap_nxt     = '0;
          state_nxt   = S_RUN;
        end
      end
      S_RUN: begin
        rd_addr_nxt = (rd_addr_r == AW'(HISTORY_DEPTH - 1)) ? '0 : rd_addr_r + AW'(1);
        tap_nxt     = tap_r + hbf_pkg::TAP_W'(1);
        if (issue_tag.last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      rd_addr_r <= '0;
      tap_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      rd_addr_r <= rd_addr_nxt;
      tap_r     <= tap_nxt;
    end
  end

  hbf_hist #(
    .DEPTH (HISTORY_DEPTH),
    .AW    (AW)
  ) u_hist (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (in_xfer),
    .wr_data  (wr_data),
    .base     (base),
    .rd_addr  (rd_addr_r),
    .rd_tag   (issue_tag),
    .rd_data  (rd_data),
    .rd_tag_q (rd_tag_q)
  );

  // Coefficients for the tap now leaving the history
  assign coef_dn = hbf_pkg::tap_coef(rd_tag_q.tap, 1'b0);
  assign coef_up = hbf_pkg::tap_coef(rd_tag_q.tap, 1'b1);

  hbf_lane u_lane_dl (
    .clk  (clk),
    .rst_n(rst_n),
    .clr  (in_xfer),
    .smp  (rd_data[15:0]),
    .coef (coef_dn),
    .tag  (rd_tag_q),
    .acc  (acc_dl),
    .done (done_v[0])
  );

  hbf_lane u_lane_dr (
    .clk  (clk),
    .rst_n(rst_n),
    .clr  (in_xfer),
    .smp  (rd_data[31:16]),
    .coef (coef_dn),
    .tag  (rd_tag_q),
    .acc  (acc_dr),
    .done (done_v[1])
  );

  hbf_lane u_lane_ul (
    .clk  (clk),
    .rst_n(rst_n),
    .clr  (in_xfer),
    .smp  (rd_data[47:32]),
    .coef (coef_up),
    .tag  (rd_tag_q),
    .acc  (acc_ul),
    .done (done_v[2])
  );

  hbf_lane u_lane_ur (
    .clk  (clk),
    .rst_n(rst_n),
    .clr  (in_xfer),
    .smp  (rd_data[63:48]),
    .coef (coef_up),
    .tag  (rd_tag_q),
    .acc  (acc_ur),
    .done (done_v[3])
  );

  hbf_merge u_merge (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (load),
    .acc_dl        (acc_dl),
    .acc_dr        (acc_dr),
    .acc_ul        (acc_ul),
    .acc_ur        (acc_ur),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_down_left (out_down_left),
    .out_down_right(out_down_right),
    .out_up_left   (out_up_left),
    .out_up_right  (out_up_right)
  );

endmodule

`default_nettype wire

FILE: hdl/hbf_hist.sv
`timescale 1ns / 1ps
`default_nettype none

// Circular sample history: one write and one registered read per cycle
module hbf_hist #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          wr_en,
  input  wire logic [hbf_pkg::ENTRY_W-1:0]   wr_data,
  output logic      [AW-1:0]                 base,
  input  wire logic [AW-1:0]                 rd_addr,
  input  wire hbf_pkg::hbf_tag_t             rd_tag,
  output logic      [hbf_pkg::ENTRY_W-1:0]   rd_data,
  output hbf_pkg::hbf_tag_t                  rd_tag_q
);

  logic [hbf_pkg::ENTRY_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]            ent_vld_r;
  logic [AW-1:0]               wp_r;
  logic [AW-1:0]               wp_nxt;
  logic [hbf_pkg::ENTRY_W-1:0] rd_data_r;
  logic                        rd_ok_r;
  hbf_pkg::hbf_tag_t           rd_tag_r;

  // Next write position, wrapping at the depth
  assign wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);

  // Oldest tap position once the current item has been written
  assign base = (wp_nxt >= AW'(hbf_pkg::TAP_COUNT)) ?
                (wp_nxt - AW'(hbf_pkg::TAP_COUNT)) :
                (wp_nxt + AW'(DEPTH - hbf_pkg::TAP_COUNT));

  // Storage array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp_r] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Write pointer, entry valid bits and read tag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r      <= '0;
      ent_vld_r <= '0;
      rd_ok_r   <= 1'b0;
      rd_tag_r  <= '0;
    end else begin
      if (wr_en) begin
        wp_r            <= wp_nxt;
        ent_vld_r[wp_r] <= 1'b1;
      end
      rd_ok_r  <= ent_vld_r[rd_addr];
      rd_tag_r <= rd_tag;
    end
  end

  // Never-written entries read as zero
  assign rd_data  = rd_ok_r ? rd_data_r : '0;
  assign rd_tag_q = rd_tag_r;

endmodule

`default_nettype wire

FILE: hdl/hbf_lane.sv
`timescale 1ns / 1ps
`default_nettype none

// One channel: registered multiply then accumulate, one tap per cycle
module hbf_lane (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                clr,
  input  wire logic signed [hbf_pkg::SMP_W-1:0]    smp,
  input  wire logic signed [hbf_pkg::SMP_W-1:0]    coef,
  input  wire hbf_pkg::hbf_tag_t                   tag,
  output logic signed      [hbf_pkg::ACC_W-1:0]    acc,
  output logic                                     done
);

  logic signed [hbf_pkg::PROD_W-1:0] prod_r;
  logic                              pv_r;
  logic                              pl_r;
  logic signed [hbf_pkg::ACC_W-1:0]  acc_r;
  logic                              done_r;

  // Product stage
  always_ff @(posedge clk) begin
    prod_r <= hbf_pkg::PROD_W'(smp) * hbf_pkg::PROD_W'(coef);
  end

  // Control flags and accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r   <= 1'b0;
      pl_r   <= 1'b0;
      acc_r  <= '0;
      done_r <= 1'b0;
    end else begin
      pv_r <= tag.vld;
      pl_r <= tag.last;
      if (clr) begin
        acc_r  <= '0;
        done_r <= 1'b0;
      end else if (pv_r) begin
        acc_r  <= acc_r + hbf_pkg::ACC_W'(prod_r);
        done_r <= pl_r;
      end
    end
  end

  assign acc  = acc_r;
  assign done = done_r;

endmodule

`default_nettype wire

FILE: hdl/hbf_merge.sv
`timescale 1ns / 1ps
`default_nettype none

// Merge: scale and saturate the four lane sums into the output register
module hbf_merge (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  load,
  input  wire logic signed [hbf_pkg::ACC_W-1:0]      acc_dl,
  input  wire logic signed [hbf_pkg::ACC_W-1:0]      acc_dr,
  input  wire logic signed [hbf_pkg::ACC_W-1:0]      acc_ul,
  input  wire logic signed [hbf_pkg::ACC_W-1:0]      acc_ur,
  input  wire logic                                  out_ready,
  output logic                                       out_valid,
  output logic signed      [hbf_pkg::SMP_W-1:0]      out_down_left,
  output logic signed      [hbf_pkg::SMP_W-1:0]      out_down_right,
  output logic signed      [hbf_pkg::SMP_W-1:0]      out_up_left,
  output logic signed      [hbf_pkg::SMP_W-1:0]      out_up_right
);

  localparam int SH_W = hbf_pkg::ACC_W - hbf_pkg::OUT_SHIFT;

  logic                              ov_r;
  logic signed [hbf_pkg::SMP_W-1:0]  dl_r, dr_r, ul_r, ur_r;

  // Floor shift by 15, then clamp to 16 bits
  function automatic logic signed [hbf_pkg::SMP_W-1:0] scale_sat(
      input logic signed [hbf_pkg::ACC_W-1:0] a);
    logic signed [SH_W-1:0] sh;
    sh = SH_W'(a >>> hbf_pkg::OUT_SHIFT);
    if (sh > SH_W'(32767)) begin
      scale_sat = 16'sh7fff;
    end else if (sh < -SH_W'(32768)) begin
      scale_sat = -16'sh8000;
    end else begin
      scale_sat = hbf_pkg::SMP_W'(sh);
    end
  endfunction

  // Result payload
  always_ff @(posedge clk) begin
    if (load) begin
      dl_r <= scale_sat(acc_dl);
      dr_r <= scale_sat(acc_dr);
      ul_r <= scale_sat(acc_ul);
      ur_r <= scale_sat(acc_ur);
    end
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (load) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  assign out_valid      = ov_r;
  assign out_down_left  = dl_r;
  assign out_down_right = dr_r;
  assign out_up_left    = ul_r;
  assign out_up_right   = ur_r;

endmodule

`default_nettype wire
